FILE: src/bnsa_pkg.sv
// ----------------------------------------------------------------------------
// bnsa_pkg
// Shared types, constants and helpers of the nearest-neighbor scaler address
// generator.
// ----------------------------------------------------------------------------
package bnsa_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int CFG_W       = 13;
    localparam int CRD_W       = 12;
    localparam int ADDR_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_AREA_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_AREA_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROW_STRIDE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT     = 3'd6;

    localparam logic [CFG_W-1:0] NO_ROW = '1;

    // stepping parameters for the front end
    typedef struct packed {
        logic [CFG_W-1:0] dest_w;
        logic [CFG_W-1:0] dest_h;
        logic [CFG_W-1:0] col_quo;
        logic [CRD_W-1:0] col_rem;
        logic [CFG_W-1:0] row_quo;
        logic [CRD_W-1:0] row_rem;
    } t_step_cfg;

    // source mapping for the back end
    typedef struct packed {
        logic [CRD_W-1:0] area_x;
        logic [CRD_W-1:0] area_y;
        logic [CFG_W-1:0] stride;
    } t_map_cfg;

    // one classified pixel between front and back
    typedef struct packed {
        logic [CRD_W-1:0]  src_row;
        logic [CRD_W-1:0]  src_col;
        logic [CRD_W-1:0]  dest_col;
        logic [CRD_W-1:0]  dest_row;
        logic [ADDR_W-1:0] dest_addr;
        logic              repeat_row;
        logic              row_end;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // a size of zero acts as one, an oversized one as the maximum
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = CFG_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: src/bnsa_div.sv
// ----------------------------------------------------------------------------
// bnsa_div
// Restoring divider, one quotient bit per cycle, for the size ratios.
// ----------------------------------------------------------------------------
module bnsa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bnsa_pkg::CFG_W-1:0]        i_dividend,
    input  logic [bnsa_pkg::CFG_W-1:0]        i_divisor,
    output logic                              o_busy,
    output logic [bnsa_pkg::CFG_W-1:0]        o_quo,
    output logic [bnsa_pkg::CRD_W-1:0]        o_rem
);

    localparam int W   = bnsa_pkg::CFG_W;
    localparam int CW  = $clog2(W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_quo[W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= W'(1);
            r_den  <= W'(1);
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? W'(w_sh - {1'b0, r_den}) : w_sh[W-1:0];
            r_quo  <= {r_quo[W-2:0], w_ge};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[bnsa_pkg::CRD_W-1:0];

endmodule

FILE: src/bnsa_front.sv
// ----------------------------------------------------------------------------
// bnsa_front
// Raster walker: steps destination position and the Bresenham source
// accumulators, and classifies each pixel with its row and frame flags.
// ----------------------------------------------------------------------------
module bnsa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_accept,
    input  logic                          i_restart,
    input  bnsa_pkg::t_step_cfg           i_cfg,
    output bnsa_pkg::t_item               o_item
);

    localparam int CW = bnsa_pkg::CRD_W;
    localparam int SW = bnsa_pkg::CFG_W;
    localparam int AW = bnsa_pkg::ADDR_W;

    logic [CW-1:0] r_col_cnt, r_row_cnt, r_col_err, r_row_err, r_src_col, r_src_row;
    logic [SW-1:0] r_prev_row;
    logic [AW-1:0] r_daddr;
    logic [CW-1:0] n_col_cnt, n_row_cnt, n_col_err, n_row_err, n_src_col, n_src_row;
    logic [SW-1:0] n_prev_row;
    logic [AW-1:0] n_daddr;

    logic [CW-1:0] w_col_cnt, w_row_cnt, w_col_err, w_row_err, w_src_col, w_src_row;
    logic [SW-1:0] w_prev_row;
    logic [AW-1:0] w_daddr;
    logic          w_last_col, w_last_row;
    logic [SW-1:0] w_col_sum, w_row_sum;
    logic          w_col_carry, w_row_carry;

    // a restart takes effect on the pixel that carries it
    always_comb begin
        w_col_cnt  = i_restart ? '0 : r_col_cnt;
        w_row_cnt  = i_restart ? '0 : r_row_cnt;
        w_col_err  = i_restart ? '0 : r_col_err;
        w_row_err  = i_restart ? '0 : r_row_err;
        w_src_col  = i_restart ? '0 : r_src_col;
        w_src_row  = i_restart ? '0 : r_src_row;
        w_prev_row = i_restart ? bnsa_pkg::NO_ROW : r_prev_row;
        w_daddr    = i_restart ? '0 : r_daddr;
    end

    assign w_last_col = ({1'b0, w_col_cnt} + SW'(1)) >= i_cfg.dest_w;
    assign w_last_row = ({1'b0, w_row_cnt} + SW'(1)) >= i_cfg.dest_h;

    assign w_col_sum   = {1'b0, w_col_err} + {1'b0, i_cfg.col_rem};
    assign w_col_carry = (w_col_sum >= i_cfg.dest_w);
    assign w_row_sum   = {1'b0, w_row_err} + {1'b0, i_cfg.row_rem};
    assign w_row_carry = (w_row_sum >= i_cfg.dest_h);

    always_comb begin
        o_item.src_row    = w_src_row;
        o_item.src_col    = w_src_col;
        o_item.dest_col   = w_col_cnt;
        o_item.dest_row   = w_row_cnt;
        o_item.dest_addr  = w_daddr;
        o_item.repeat_row = (w_prev_row == {1'b0, w_src_row});
        o_item.row_end    = w_last_col;
        o_item.frame_end  = w_last_col && w_last_row;
    end

    always_comb begin
        n_col_cnt  = w_col_cnt;
        n_row_cnt  = w_row_cnt;
        n_col_err  = w_col_err;
        n_row_err  = w_row_err;
        n_src_col  = w_src_col;
        n_src_row  = w_src_row;
        n_prev_row = w_prev_row;
        n_daddr    = w_daddr + AW'(1);
        if (!w_last_col) begin
            n_col_cnt = w_col_cnt + CW'(1);
            n_col_err = w_col_carry ? CW'(w_col_sum - i_cfg.dest_w) : w_col_sum[CW-1:0];
            n_src_col = CW'({1'b0, w_src_col} + i_cfg.col_quo + SW'(w_col_carry));
        end else if (!w_last_row) begin
            n_prev_row = {1'b0, w_src_row};
            n_col_cnt  = '0;
            n_col_err  = '0;
            n_src_col  = '0;
            n_row_cnt  = w_row_cnt + CW'(1);
            n_row_err  = w_row_carry ? CW'(w_row_sum - i_cfg.dest_h) : w_row_sum[CW-1:0];
            n_src_row  = CW'({1'b0, w_src_row} + i_cfg.row_quo + SW'(w_row_carry));
        end else begin
            // wrap to a fresh frame
            n_col_cnt  = '0;
            n_row_cnt  = '0;
            n_col_err  = '0;
            n_row_err  = '0;
            n_src_col  = '0;
            n_src_row  = '0;
            n_prev_row = bnsa_pkg::NO_ROW;
            n_daddr    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_col_err  <= '0;
            r_row_err  <= '0;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_prev_row <= bnsa_pkg::NO_ROW;
            r_daddr    <= '0;
        end else if (i_accept) begin
            r_col_cnt  <= n_col_cnt;
            r_row_cnt  <= n_row_cnt;
            r_col_err  <= n_col_err;
            r_row_err  <= n_row_err;
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_prev_row <= n_prev_row;
            r_daddr    <= n_daddr;
        end
    end

endmodule

FILE: src/bnsa_queue.sv
// ----------------------------------------------------------------------------
// bnsa_queue
// Short FIFO of classified pixels between the walker and the address stage.
// ----------------------------------------------------------------------------
module bnsa_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bnsa_pkg::t_item      i_item,
    input  logic                 i_pop,
    output bnsa_pkg::t_item      o_item,
    output bnsa_pkg::t_queue_stat o_stat
);

    localparam int D  = bnsa_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);
    localparam int NW = $clog2(D + 1);

    bnsa_pkg::t_item r_mem [D];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == D - 1) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == D - 1) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    assign o_item = r_mem[r_rd_ptr];

    always_comb begin
        o_stat.full  = (r_count == NW'(D));
        o_stat.empty = (r_count == '0);
    end

endmodule

FILE: src/bnsa_back.sv
// ----------------------------------------------------------------------------
// bnsa_back
// Two-stage address pipeline: row base multiply, then column add. The second
// stage is the output register.
// ----------------------------------------------------------------------------
module bnsa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bnsa_pkg::t_map_cfg            i_cfg,
    input  logic                          i_avail,
    input  bnsa_pkg::t_item               i_item,
    output logic                          o_take,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bnsa_pkg::ADDR_W-1:0]   o_src_addr,
    output bnsa_pkg::t_item               o_item
);

    localparam int SW = bnsa_pkg::CFG_W;
    localparam int AW = bnsa_pkg::ADDR_W;

    logic            r_v1, r_v2;
    logic [AW-1:0]   r_base;
    logic [SW-1:0]   r_col;
    bnsa_pkg::t_item r_item1, r_item2;
    logic [AW-1:0]   r_src_addr;

    logic            w_adv2, w_adv1;
    logic [SW-1:0]   w_row;
    logic [2*SW-1:0] w_prod;

    assign w_adv2 = !r_v2 || i_out_ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_take = i_avail && w_adv1;

    assign w_row  = {1'b0, i_cfg.area_y} + {1'b0, i_item.src_row};
    assign w_prod = w_row * i_cfg.stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_avail;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_base  <= w_prod[AW-1:0];
            r_col   <= {1'b0, i_cfg.area_x} + {1'b0, i_item.src_col};
            r_item1 <= i_item;
        end
        if (w_adv2 && r_v1) begin
            r_src_addr <= r_base + AW'(r_col);
            r_item2    <= r_item1;
        end
    end

    assign o_out_valid = r_v2;
    assign o_src_addr  = r_src_addr;
    assign o_item      = r_item2;

endmodule

FILE: src/bresenham_nearest_scaler_addr_unit.sv
// ----------------------------------------------------------------------------
// bresenham_nearest_scaler_addr_unit
// Nearest-neighbor resize address generator using Bresenham coarse scaling.
// ----------------------------------------------------------------------------
// Each input transaction asks for the next destination pixel in raster order
// (i_restart = 1 starts over at the first pixel); each yields one output
// transaction with source and destination addresses, coordinates, the
// repeat-row flag and the row and frame end flags.
// Throughput is one pixel per clock while no division runs and the receiver
// keeps up: the walker steps its accumulators combinationally and a
// four-entry queue feeds the address pipeline. An accepted transaction
// reaches the output through the queue, the row base and the output register.
// When the receiver stalls, the output register holds, the queue fills, and
// o_in_ready drops once the queue is full. Configuration writes with a valid
// index restart the frame and start the two size-ratio divisions, one
// quotient bit per cycle; both o_in_ready and o_cfg_ready then stay low until
// the divisions finish. Reset clears the position to the first pixel and the
// registers to area origin 0 and all sizes 1; no pixel is pending afterwards.
// ----------------------------------------------------------------------------
module bresenham_nearest_scaler_addr_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bnsa_pkg::ADDR_W-1:0]        o_src_addr,
    output logic [bnsa_pkg::ADDR_W-1:0]        o_dest_addr,
    output logic [bnsa_pkg::CRD_W-1:0]         o_dest_col,
    output logic [bnsa_pkg::CRD_W-1:0]         o_dest_row,
    output logic                               o_repeat_row,
    output logic                               o_row_end,
    output logic                               o_frame_end,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bnsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bnsa_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int CW = bnsa_pkg::CRD_W;
    localparam int SW = bnsa_pkg::CFG_W;

    logic [CW-1:0] r_area_x, r_area_y;
    logic [SW-1:0] r_area_w, r_area_h, r_stride, r_dest_w, r_dest_h;
    logic          r_div_start;

    logic          w_cfg_acc, w_cfg_hit, w_busy, w_col_busy, w_row_busy;
    logic          w_in_acc, w_take;
    logic [SW-1:0] w_sw, w_sh, w_dw, w_dh;
    logic [SW-1:0] w_col_quo, w_row_quo;
    logic [CW-1:0] w_col_rem, w_row_rem;

    bnsa_pkg::t_step_cfg   w_step_cfg;
    bnsa_pkg::t_map_cfg    w_map_cfg;
    bnsa_pkg::t_item       w_front_item, w_queue_item, w_out_item;
    bnsa_pkg::t_queue_stat w_qstat;

    assign w_busy      = r_div_start || w_col_busy || w_row_busy;
    assign o_cfg_ready = !w_busy;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !w_busy && !w_qstat.full;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        case (i_cfg_index)
            bnsa_pkg::CFG_SRC_AREA_X,
            bnsa_pkg::CFG_SRC_AREA_Y,
            bnsa_pkg::CFG_SRC_AREA_WIDTH,
            bnsa_pkg::CFG_SRC_AREA_HEIGHT,
            bnsa_pkg::CFG_SRC_ROW_STRIDE,
            bnsa_pkg::CFG_DEST_WIDTH,
            bnsa_pkg::CFG_DEST_HEIGHT: w_cfg_hit = w_cfg_acc;
            default:                   w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_x    <= '0;
            r_area_y    <= '0;
            r_area_w    <= SW'(1);
            r_area_h    <= SW'(1);
            r_stride    <= SW'(1);
            r_dest_w    <= SW'(1);
            r_dest_h    <= SW'(1);
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= w_cfg_hit;
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    bnsa_pkg::CFG_SRC_AREA_X:      r_area_x <= i_cfg_data[CW-1:0];
                    bnsa_pkg::CFG_SRC_AREA_Y:      r_area_y <= i_cfg_data[CW-1:0];
                    bnsa_pkg::CFG_SRC_AREA_WIDTH:  r_area_w <= i_cfg_data;
                    bnsa_pkg::CFG_SRC_AREA_HEIGHT: r_area_h <= i_cfg_data;
                    bnsa_pkg::CFG_SRC_ROW_STRIDE:  r_stride <= i_cfg_data;
                    bnsa_pkg::CFG_DEST_WIDTH:      r_dest_w <= i_cfg_data;
                    bnsa_pkg::CFG_DEST_HEIGHT:     r_dest_h <= i_cfg_data;
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    assign w_sw = bnsa_pkg::eff_size(r_area_w);
    assign w_sh = bnsa_pkg::eff_size(r_area_h);
    assign w_dw = bnsa_pkg::eff_size(r_dest_w);
    assign w_dh = bnsa_pkg::eff_size(r_dest_h);

    bnsa_div u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_sw),
        .i_divisor  (w_dw),
        .o_busy     (w_col_busy),
        .o_quo      (w_col_quo),
        .o_rem      (w_col_rem)
    );

    bnsa_div u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_sh),
        .i_divisor  (w_dh),
        .o_busy     (w_row_busy),
        .o_quo      (w_row_quo),
        .o_rem      (w_row_rem)
    );

    always_comb begin
        w_step_cfg.dest_w  = w_dw;
        w_step_cfg.dest_h  = w_dh;
        w_step_cfg.col_quo = w_col_quo;
        w_step_cfg.col_rem = w_col_rem;
        w_step_cfg.row_quo = w_row_quo;
        w_step_cfg.row_rem = w_row_rem;
    end

    always_comb begin
        w_map_cfg.area_x = r_area_x;
        w_map_cfg.area_y = r_area_y;
        w_map_cfg.stride = r_stride;
    end

    bnsa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_cfg_hit),
        .i_accept  (w_in_acc),
        .i_restart (i_restart),
        .i_cfg     (w_step_cfg),
        .o_item    (w_front_item)
    );

    bnsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_acc),
        .i_item  (w_front_item),
        .i_pop   (w_take),
        .o_item  (w_queue_item),
        .o_stat  (w_qstat)
    );

    bnsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_map_cfg),
        .i_avail     (!w_qstat.empty),
        .i_item      (w_queue_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_src_addr  (o_src_addr),
        .o_item      (w_out_item)
    );

    assign o_dest_addr  = w_out_item.dest_addr;
    assign o_dest_col   = w_out_item.dest_col;
    assign o_dest_row   = w_out_item.dest_row;
    assign o_repeat_row = w_out_item.repeat_row;
    assign o_row_end    = w_out_item.row_end;
    assign o_frame_end  = w_out_item.frame_end;

endmodule

FILE: tb/bnsa_addr_checker.sv
// ----------------------------------------------------------------------------
// bnsa_addr_checker
// Watches the pixel request, pixel result and register write channels of the
// scaler address generator. It walks its own copy of the Bresenham position
// state, queues the expected pixel for every accepted request and compares
// each accepted result with the oldest queued pixel.
// ----------------------------------------------------------------------------
module bnsa_addr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_restart,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [bnsa_pkg::ADDR_W-1:0]       i_src_addr,
    input  logic [bnsa_pkg::ADDR_W-1:0]       i_dest_addr,
    input  logic [bnsa_pkg::CRD_W-1:0]        i_dest_col,
    input  logic [bnsa_pkg::CRD_W-1:0]        i_dest_row,
    input  logic                              i_repeat_row,
    input  logic                              i_row_end,
    input  logic                              i_frame_end,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [bnsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bnsa_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int AW = bnsa_pkg::ADDR_W;
    localparam int CW = bnsa_pkg::CRD_W;
    localparam int SW = bnsa_pkg::CFG_W;
    localparam int IW = bnsa_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [AW-1:0] src_addr;
        logic [AW-1:0] dest_addr;
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic          repeat_row;
        logic          row_end;
        logic          frame_end;
    } t_pixel;

    // register copy
    bit [CW-1:0] area_x, area_y;
    bit [SW-1:0] area_w, area_h, row_stride, dst_w, dst_h;

    // walker copy
    bit [CW-1:0] col_cnt, row_cnt, col_err, row_err, src_col, src_row;
    bit [SW-1:0] last_src_row;

    t_pixel expected_pixels[$];

    function automatic int unsigned clamp_dim(bit [SW-1:0] v);
        if (v == 0)
            return 1;
        if (32'(v) > bnsa_pkg::MAX_DIM)
            return bnsa_pkg::MAX_DIM;
        return 32'(v);
    endfunction

    function automatic void restart_walk();
        col_cnt      = '0;
        row_cnt      = '0;
        col_err      = '0;
        row_err      = '0;
        src_col      = '0;
        src_row      = '0;
        last_src_row = bnsa_pkg::NO_ROW;
    endfunction

    function automatic void apply_write(bit [IW-1:0] idx, bit [SW-1:0] data);
        bit known;
        known = 1'b1;
        case (idx)
            bnsa_pkg::CFG_SRC_AREA_X:      area_x     = data[CW-1:0];
            bnsa_pkg::CFG_SRC_AREA_Y:      area_y     = data[CW-1:0];
            bnsa_pkg::CFG_SRC_AREA_WIDTH:  area_w     = data;
            bnsa_pkg::CFG_SRC_AREA_HEIGHT: area_h     = data;
            bnsa_pkg::CFG_SRC_ROW_STRIDE:  row_stride = data;
            bnsa_pkg::CFG_DEST_WIDTH:      dst_w      = data;
            bnsa_pkg::CFG_DEST_HEIGHT:     dst_h      = data;
            default:                       known      = 1'b0;
        endcase
        // any write to a real register starts the frame over
        if (known)
            restart_walk();
    endfunction

    // produce the next destination pixel and advance the walker
    function automatic t_pixel walk_pixel(bit restart);
        int unsigned sw, sh, dw, dh, pos_acc, err_acc, saddr, daddr;
        bit          last_col, last_row;
        t_pixel      p;
        sw = clamp_dim(area_w);
        sh = clamp_dim(area_h);
        dw = clamp_dim(dst_w);
        dh = clamp_dim(dst_h);
        if (restart)
            restart_walk();
        last_col = 32'(col_cnt) + 1 >= dw;
        last_row = 32'(row_cnt) + 1 >= dh;
        saddr = (32'(area_y) + 32'(src_row)) * 32'(row_stride)
              + 32'(area_x) + 32'(src_col);
        daddr = 32'(row_cnt) * dw + 32'(col_cnt);
        p.src_addr   = saddr[AW-1:0];
        p.dest_addr  = daddr[AW-1:0];
        p.col        = col_cnt;
        p.row        = row_cnt;
        p.repeat_row = (last_src_row == {1'b0, src_row});
        p.row_end    = last_col;
        p.frame_end  = last_col && last_row;
        if (!last_col) begin
            col_cnt = col_cnt + 1'b1;
            pos_acc = 32'(src_col) + sw / dw;
            err_acc = 32'(col_err) + sw % dw;
            if (err_acc >= dw) begin
                err_acc = err_acc - dw;
                pos_acc = pos_acc + 1;
            end
            src_col = pos_acc[CW-1:0];
            col_err = err_acc[CW-1:0];
        end else if (!last_row) begin
            last_src_row = {1'b0, src_row};
            col_cnt = '0;
            col_err = '0;
            src_col = '0;
            row_cnt = row_cnt + 1'b1;
            pos_acc = 32'(src_row) + sh / dh;
            err_acc = 32'(row_err) + sh % dh;
            if (err_acc >= dh) begin
                err_acc = err_acc - dh;
                pos_acc = pos_acc + 1;
            end
            src_row = pos_acc[CW-1:0];
            row_err = err_acc[CW-1:0];
        end else begin
            // wrap to the first pixel of a new frame
            restart_walk();
        end
        return p;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel want, got;
        if (!i_rst_n) begin
            area_x     = '0;
            area_y     = '0;
            area_w     = SW'(1);
            area_h     = SW'(1);
            row_stride = SW'(1);
            dst_w      = SW'(1);
            dst_h      = SW'(1);
            restart_walk();
            expected_pixels.delete();
        end else begin
            // compare before queuing: a result never belongs to a request of the same edge
            if (i_out_valid && i_out_ready) begin
                got = '{i_src_addr, i_dest_addr, i_dest_col, i_dest_row,
                        i_repeat_row, i_row_end, i_frame_end};
                if (expected_pixels.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected pixel src %h dest %h col %0d row %0d",
                                 $time, got.src_addr, got.dest_addr, got.col, got.row);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: pixel mismatch", $time);
                            $display("  expected src %h dest %h col %0d row %0d",
                                     want.src_addr, want.dest_addr, want.col, want.row);
                            $display("           rep %b re %b fe %b",
                                     want.repeat_row, want.row_end, want.frame_end);
                            $display("  actual   src %h dest %h col %0d row %0d",
                                     got.src_addr, got.dest_addr, got.col, got.row);
                            $display("           rep %b re %b fe %b",
                                     got.repeat_row, got.row_end, got.frame_end);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(walk_pixel(i_restart));
        end
        o_pending = expected_pixels.size();
    end

endmodule

FILE: tb/tb_bresenham_nearest_scaler_addr_unit.sv
// ----------------------------------------------------------------------------
// tb_bresenham_nearest_scaler_addr_unit
// Drives pixel requests and register writes into the scaler address unit and
// stalls the result side; a checker beside the block predicts every pixel.
// A directed opening covers the reset sizes, address wrap, size clamping, the
// unused register index and repeated source rows, then random register sets
// and request streams run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_bresenham_nearest_scaler_addr_unit;

    localparam int AW = bnsa_pkg::ADDR_W;
    localparam int CW = bnsa_pkg::CRD_W;
    localparam int SW = bnsa_pkg::CFG_W;
    localparam int IW = bnsa_pkg::CFG_IDX_W;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam logic [IW-1:0] CFG_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 64;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic          i_restart;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [AW-1:0] o_src_addr;
    logic [AW-1:0] o_dest_addr;
    logic [CW-1:0] o_dest_col;
    logic [CW-1:0] o_dest_row;
    logic          o_repeat_row;
    logic          o_row_end;
    logic          o_frame_end;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [IW-1:0] i_cfg_index;
    logic [SW-1:0] i_cfg_data;

    int         fail_count;
    int         pending;
    t_idle_mode idle_mode;
    bit         burst_tog;

    bresenham_nearest_scaler_addr_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_src_addr   (o_src_addr),
        .o_dest_addr  (o_dest_addr),
        .o_dest_col   (o_dest_col),
        .o_dest_row   (o_dest_row),
        .o_repeat_row (o_repeat_row),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    bnsa_addr_checker u_addr_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_src_addr   (o_src_addr),
        .i_dest_addr  (o_dest_addr),
        .i_dest_col   (o_dest_col),
        .i_dest_row   (o_dest_row),
        .i_repeat_row (o_repeat_row),
        .i_row_end    (o_row_end),
        .i_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: snapshot the mode at the rising edge, drive ready at the falling one
    initial begin : rx_side
        int         hold_left;
        bit         burst_seen;
        t_idle_mode mode_now;
        hold_left   = 0;
        burst_seen  = 1'b0;
        i_out_ready = 1'b1;
        forever begin
            @(posedge i_clk);
            mode_now = idle_mode;
            if (burst_tog != burst_seen) begin
                burst_seen = burst_tog;
                hold_left  = LONG_HOLD;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left   = hold_left - 1;
            end else begin
                case (mode_now)
                    IDLE_RECV: i_out_ready = $urandom_range(99) >= 58;
                    IDLE_BOTH: i_out_ready = $urandom_range(99) >= 15;
                    default:   i_out_ready = 1'b1;
                endcase
            end
        end
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic cfg_write(input logic [IW-1:0] idx, input logic [SW-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // in three calls of five, write a register with a value drawn from its interesting classes
    task automatic cfg_random(input logic [IW-1:0] idx);
        logic [SW-1:0] v;
        int            pick;
        pick = $urandom_range(9);
        case (idx)
            bnsa_pkg::CFG_SRC_AREA_X, bnsa_pkg::CFG_SRC_AREA_Y:
                v = (pick < 2) ? '0 : (pick < 4) ? 13'd4095 : SW'($urandom);
            bnsa_pkg::CFG_SRC_AREA_WIDTH, bnsa_pkg::CFG_SRC_AREA_HEIGHT:
                case (pick)
                    0:       v = '0;
                    1:       v = 13'd4096;
                    2:       v = SW'($urandom_range(8191, 4097));
                    3, 4, 5: v = SW'($urandom_range(16, 1));
                    default: v = SW'($urandom_range(4096, 1));
                endcase
            bnsa_pkg::CFG_SRC_ROW_STRIDE:
                v = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? 13'd1 : SW'($urandom);
            bnsa_pkg::CFG_DEST_WIDTH, bnsa_pkg::CFG_DEST_HEIGHT:
                // keep frames short so most phases wrap through frame end
                if ($urandom_range(99) < 4)
                    v = ($urandom_range(1)) ? 13'd4096 : '1;
                else if (pick == 0)
                    v = '0;
                else
                    v = SW'($urandom_range(10, 1));
            default:
                v = SW'($urandom);
        endcase
        if ($urandom_range(99) < 60)
            cfg_write(idx, v);
    endtask

    task automatic request_pixel(input bit restart);
        int gap_pct;
        case (idle_mode)
            IDLE_SEND: gap_pct = 58;
            IDLE_BOTH: gap_pct = 15;
            default:   gap_pct = 0;
        endcase
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < gap_pct)
                @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_restart  = restart;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic request_pattern(input bit [15:0] restarts, input int n);
        for (int k = 0; k < n; k++)
            request_pixel(restarts[k]);
    endtask

    // drop valid and hold until every queued pixel has come back
    task automatic wait_drained();
        i_in_valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stim
        int n_sent;
        int n_phase;
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bnsa_pkg::CFG_SRC_AREA_X;
        i_cfg_data  = '0;
        idle_mode   = IDLE_NONE;
        burst_tog   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset sizes: every pixel closes a one-pixel frame
        request_pattern(16'b100, 3);
        wait_drained();

        // origin at the far corner, widest stride: source address wraps
        cfg_write(bnsa_pkg::CFG_SRC_AREA_X, '1);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_Y, 13'd4095);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_WIDTH, 13'd4096);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_HEIGHT, 13'd4096);
        cfg_write(bnsa_pkg::CFG_SRC_ROW_STRIDE, '1);
        cfg_write(bnsa_pkg::CFG_DEST_WIDTH, 13'd2);
        cfg_write(bnsa_pkg::CFG_DEST_HEIGHT, 13'd2);
        i_cfg_valid = 1'b0;
        request_pattern(16'b0100000, 7);
        wait_drained();

        // zero and oversized sizes clamp; the unused index is ignored
        cfg_write(bnsa_pkg::CFG_SRC_AREA_X, '0);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_Y, '0);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_WIDTH, '0);
        cfg_write(bnsa_pkg::CFG_SRC_AREA_HEIGHT, 13'd1);
        cfg_write(bnsa_pkg::CFG_SRC_ROW_STRIDE, '0);
        cfg_write(bnsa_pkg::CFG_DEST_WIDTH, 13'd3);
        cfg_write(bnsa_pkg::CFG_DEST_HEIGHT, '1);
        cfg_write(CFG_UNUSED, 13'h0a5a);
        i_cfg_valid = 1'b0;
        request_pattern(16'b0, 10);
        wait_drained();

        n_sent = 0;
        phase  = 0;
        while (n_sent < RANDOM_ITEMS) begin
            cfg_random(bnsa_pkg::CFG_SRC_AREA_X);
            cfg_random(bnsa_pkg::CFG_SRC_AREA_Y);
            cfg_random(bnsa_pkg::CFG_SRC_AREA_WIDTH);
            cfg_random(bnsa_pkg::CFG_SRC_AREA_HEIGHT);
            cfg_random(bnsa_pkg::CFG_SRC_ROW_STRIDE);
            cfg_random(bnsa_pkg::CFG_DEST_WIDTH);
            cfg_random(bnsa_pkg::CFG_DEST_HEIGHT);
            if ($urandom_range(9) == 0)
                cfg_write(CFG_UNUSED, SW'($urandom));
            i_cfg_valid = 1'b0;
            idle_mode = t_idle_mode'(phase % 4);
            n_phase   = $urandom_range(70, 30);
            if (phase == 4) begin
                // long receiver hold with a steady sender fills the block
                burst_tog = ~burst_tog;
                n_phase   = 100;
            end
            for (int k = 0; k < n_phase; k++)
                request_pixel($urandom_range(99) < 4);
            n_sent = n_sent + n_phase;
            wait_drained();
            phase = phase + 1;
        end

        idle_mode = IDLE_NONE;
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
src/bnsa_pkg.sv
src/bnsa_div.sv
src/bnsa_front.sv
src/bnsa_queue.sv
src/bnsa_back.sv
src/bresenham_nearest_scaler_addr_unit.sv
tb/bnsa_addr_checker.sv
tb/tb_bresenham_nearest_scaler_addr_unit.sv
